/* sv/ffha_pkg.sv */
// ffha_pkg: shared constants for the first-fit heap allocator
// no dependencies
`default_nettype none
package ffha_pkg;
  localparam int HEAP_BYTES_D      = 65536;
  localparam int HEADER_BYTES_D    = 12;
  localparam int MIN_SPLIT_BYTES_D = 16;
  localparam int MAX_BLOCKS_D      = 256;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NOFIT   = 2'd1;
  localparam logic [1:0] ST_UNKNOWN = 2'd2;

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;
endpackage
`default_nettype wire

/* sv/first_fit_heap_allocator_core.sv */
// first_fit_heap_allocator_core: top level with sequencer, plus ffha_ram used for the
// block descriptor memory and the spare slot stack
// depends on ffha_pkg
//
//  channel | ports                                   | direction
//  in      | in_valid in_stall in_cmd in_req_size    | to core
//          | in_payload_addr                         |
//  out     | out_valid out_stall out_status          | from core
//          | out_result_addr                         |
//
// allocate: an accept state, a read and an evaluate state per list block walked,
// the split states S_SPL and S_SPL2 when the block is split, and S_OUT to post
// free: a read and evaluate per block to find it, a reread of the head (S_M0,
// S_M0E), a read and evaluate per block in the merge walk, then S_OUT to post
// after reset a clearing pass fills the spare stack; no beat is taken meanwhile.
// a result waits in the output register while out_stall is high; in_stall stays
// high until it is gone
`default_nettype none
module ffha_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  parameter int AW    = 8
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    wa,
  input  wire logic [WIDTH-1:0] wd,
  input  wire logic [AW-1:0]    ra,
  output logic      [WIDTH-1:0] rd_r
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[wa] <= wd;
    rd_r <= mem[ra];
  end
endmodule

module first_fit_heap_allocator_core #(
  parameter int HEAP_BYTES      = ffha_pkg::HEAP_BYTES_D,
  parameter int HEADER_BYTES    = ffha_pkg::HEADER_BYTES_D,
  parameter int MIN_SPLIT_BYTES = ffha_pkg::MIN_SPLIT_BYTES_D,
  parameter int MAX_BLOCKS      = ffha_pkg::MAX_BLOCKS_D
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_cmd,
  input  wire logic [15:0] in_req_size,
  input  wire logic [15:0] in_payload_addr,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       out_status,
  output logic [15:0]      out_result_addr
);
  localparam int SW = $clog2(MAX_BLOCKS);
  localparam int LW = SW + 1;
  localparam int CW = $clog2(MAX_BLOCKS + 1);
  // descriptor word: start(17) len(17) free(1) link(LW)
  localparam int DW = 17 + 17 + 1 + LW;
  localparam logic [LW-1:0] LNULL    = LW'(MAX_BLOCKS);
  localparam logic [16:0]   INIT_LEN = 17'(HEAP_BYTES - HEADER_BYTES);
  localparam logic [16:0]   HDR      = 17'(HEADER_BYTES);
  localparam logic [17:0]   SPL      = 18'(HEADER_BYTES + MIN_SPLIT_BYTES);
  localparam logic [CW-1:0] BLK_CNT  = CW'(MAX_BLOCKS);
  localparam logic [CW-1:0] CLR_LAST = CW'(MAX_BLOCKS - 2);
  localparam logic [CW-1:0] CNT_INIT = CW'(MAX_BLOCKS - 1);
  localparam logic [SW-1:0] TOP_SLOT = SW'(MAX_BLOCKS - 1);

  localparam logic [3:0] S_CLR = 4'd0, S_IDLE = 4'd1, S_RD = 4'd2, S_EV = 4'd3,
                         S_SPL = 4'd4, S_SPL2 = 4'd5, S_M0 = 4'd6, S_M0E = 4'd7,
                         S_MRD = 4'd8, S_MEV = 4'd9, S_OUT = 4'd10;

  logic [DW-1:0] drd_r;
  logic [SW-1:0] srd_r;
  logic          dwe, swe;
  logic [SW-1:0] dwa, dra, swa, sra;
  logic [DW-1:0] dwd;
  logic [SW-1:0] swd;

  ffha_ram #(.WIDTH(DW), .DEPTH(MAX_BLOCKS), .AW(SW)) i_desc (
    .clk(clk), .we(dwe), .wa(dwa), .wd(dwd), .ra(dra), .rd_r(drd_r)
  );

  ffha_ram #(.WIDTH(SW), .DEPTH(MAX_BLOCKS), .AW(SW)) i_spare (
    .clk(clk), .we(swe), .wa(swa), .wd(swd), .ra(sra), .rd_r(srd_r)
  );

  logic [3:0]    st_r, st_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [LW-1:0] cur_r, cur_nxt, prv_r, prv_nxt, ns_r, ns_nxt;
  logic [CW-1:0] grd_r, grd_nxt;
  logic          cmd_r, cmd_nxt;
  logic [15:0]   sz_r, sz_nxt, pa_r, pa_nxt;
  logic [DW-1:0] cd_r, cd_nxt, pd_r, pd_nxt;
  logic [1:0]    ost_r, ost_nxt;
  logic [15:0]   oad_r, oad_nxt;
  logic          ov_r, ov_nxt;

  logic [16:0]   r_st, r_ln, c_st, c_ln, p_st, p_ln;
  logic          r_fr, p_fr;
  logic [LW-1:0] r_lk, c_lk;
  logic [CW-1:0] cnt_dec;
  assign {r_st, r_ln, r_fr, r_lk} = drd_r;
  assign c_st = cd_r[DW-1 -: 17];
  assign c_ln = cd_r[DW-18 -: 17];
  assign c_lk = cd_r[LW-1:0];
  assign p_st = pd_r[DW-1 -: 17];
  assign p_ln = pd_r[DW-18 -: 17];
  assign p_fr = pd_r[LW];
  assign cnt_dec = cnt_r - CW'(1);

  assign in_stall        = (st_r != S_IDLE) || ov_r;
  assign out_valid       = ov_r;
  assign out_status      = ost_r;
  assign out_result_addr = oad_r;

  always_comb begin
    st_nxt = st_r; cnt_nxt = cnt_r; cur_nxt = cur_r; prv_nxt = prv_r;
    ns_nxt = ns_r; grd_nxt = grd_r; cmd_nxt = cmd_r; sz_nxt = sz_r;
    pa_nxt = pa_r; cd_nxt = cd_r; pd_nxt = pd_r; ost_nxt = ost_r;
    oad_nxt = oad_r;
    ov_nxt = ov_r && out_stall;
    dwe = 1'b0; dwa = '0; dwd = '0; dra = '0;
    swe = 1'b0; swa = '0; swd = '0; sra = '0;
    unique case (st_r)
      S_CLR: begin
        swe = 1'b1; swa = cnt_r[SW-1:0];
        swd = TOP_SLOT - cnt_r[SW-1:0];
        if (cnt_r == '0) begin
          dwe = 1'b1; dwa = '0; dwd = {17'd0, INIT_LEN, 1'b1, LNULL};
        end
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CLR_LAST) begin
          cnt_nxt = CNT_INIT; st_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          cmd_nxt = in_cmd; sz_nxt = in_req_size; pa_nxt = in_payload_addr;
          cur_nxt = '0; grd_nxt = '0;
          if (in_cmd == ffha_pkg::CMD_ALLOC && in_req_size == 16'd0) begin
            ost_nxt = ffha_pkg::ST_NOFIT; oad_nxt = '0; st_nxt = S_OUT;
          end else begin
            st_nxt = S_RD;
          end
        end
      end
      S_RD: begin
        if (cur_r >= LNULL || grd_r >= BLK_CNT) begin
          ost_nxt = (cmd_r == ffha_pkg::CMD_FREE) ? ffha_pkg::ST_UNKNOWN
                                                  : ffha_pkg::ST_NOFIT;
          oad_nxt = '0; st_nxt = S_OUT;
        end else begin
          dra = cur_r[SW-1:0]; st_nxt = S_EV;
        end
      end
      S_EV: begin
        cd_nxt = drd_r;
        grd_nxt = grd_r + CW'(1);
        if (cmd_r == ffha_pkg::CMD_FREE) begin
          if (r_st + HDR == {1'b0, pa_r}) begin
            dwe = 1'b1; dwa = cur_r[SW-1:0];
            dwd = {r_st, r_ln, 1'b1, r_lk};
            ost_nxt = ffha_pkg::ST_OK; oad_nxt = '0;
            st_nxt = S_M0;
          end else begin
            cur_nxt = r_lk; st_nxt = S_RD;
          end
        end else if (r_fr && r_ln >= {1'b0, sz_r}) begin
          oad_nxt = 16'(r_st + HDR); ost_nxt = ffha_pkg::ST_OK;
          if ({1'b0, r_ln} >= {2'b0, sz_r} + SPL && cnt_r != '0) begin
            // pop a spare slot for the tail block
            sra = cnt_dec[SW-1:0]; cnt_nxt = cnt_dec; st_nxt = S_SPL;
          end else begin
            dwe = 1'b1; dwa = cur_r[SW-1:0];
            dwd = {r_st, r_ln, 1'b0, r_lk};
            st_nxt = S_OUT;
          end
        end else begin
          cur_nxt = r_lk; st_nxt = S_RD;
        end
      end
      S_SPL: begin
        // new free tail block, then shrink the taken one
        dwe = 1'b1; dwa = srd_r;
        dwd = {17'(c_st + HDR + {1'b0, sz_r}),
               17'(c_ln - {1'b0, sz_r} - HDR), 1'b1, c_lk};
        ns_nxt = {1'b0, srd_r}; st_nxt = S_SPL2;
      end
      S_SPL2: begin
        dwe = 1'b1; dwa = cur_r[SW-1:0];
        dwd = {c_st, {1'b0, sz_r}, 1'b0, ns_r};
        st_nxt = S_OUT;
      end
      S_M0: begin
        dra = '0; st_nxt = S_M0E;
      end
      S_M0E: begin
        pd_nxt = drd_r; prv_nxt = '0; cur_nxt = r_lk; grd_nxt = '0;
        st_nxt = S_MRD;
      end
      S_MRD: begin
        if (cur_r >= LNULL || grd_r >= BLK_CNT) begin
          st_nxt = S_OUT;
        end else begin
          dra = cur_r[SW-1:0]; st_nxt = S_MEV;
        end
      end
      S_MEV: begin
        grd_nxt = grd_r + CW'(1);
        cur_nxt = r_lk;
        st_nxt = S_MRD;
        if (p_fr && r_fr) begin
          // absorb cur into prev and hand its slot back
          pd_nxt = {p_st, 17'(p_ln + r_ln + HDR), 1'b1, r_lk};
          dwe = 1'b1; dwa = prv_r[SW-1:0];
          dwd = {p_st, 17'(p_ln + r_ln + HDR), 1'b1, r_lk};
          if (cnt_r < BLK_CNT) begin
            swe = 1'b1; swa = cnt_r[SW-1:0]; swd = cur_r[SW-1:0];
            cnt_nxt = cnt_r + CW'(1);
          end
        end else begin
          prv_nxt = cur_r; pd_nxt = drd_r;
        end
      end
      S_OUT: begin
        ov_nxt = 1'b1; st_nxt = S_IDLE;
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; cnt_r <= '0; ov_r <= 1'b0;
      cur_r <= '0; prv_r <= '0; ns_r <= '0; grd_r <= '0; cmd_r <= 1'b0;
      sz_r <= '0; pa_r <= '0; cd_r <= '0; pd_r <= '0;
      ost_r <= ffha_pkg::ST_OK; oad_r <= '0;
    end else begin
      st_r <= st_nxt; cnt_r <= cnt_nxt; ov_r <= ov_nxt;
      cur_r <= cur_nxt; prv_r <= prv_nxt; ns_r <= ns_nxt; grd_r <= grd_nxt;
      cmd_r <= cmd_nxt; sz_r <= sz_nxt; pa_r <= pa_nxt; cd_r <= cd_nxt;
      pd_r <= pd_nxt; ost_r <= ost_nxt; oad_r <= oad_nxt;
    end
  end
endmodule
`default_nettype wire
